// File: sv/integer_to_radix_digit_string_top_defines.svh
// Assertion macros shared by the digit string conversion RTL.
`ifndef INTEGER_TO_RADIX_DIGIT_STRING_TOP_DEFINES_SVH
`define INTEGER_TO_RADIX_DIGIT_STRING_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define ITRD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as its antecedent.
`define ITRD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence that must hold in the cycle after its antecedent.
`define ITRD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/itrd_pkg.sv
// Types, constants and the symbol lookup for the digit string converter.
`timescale 1ns / 1ps

package itrd_pkg;

    // Width of the value that is actually converted, and depth of the digit store.
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 64;

    // Fixed field widths.
    localparam int IN_VALUE_W = 64;
    localparam int BASE_W     = 7;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 8;

    // Accepted range of the base.
    localparam logic [BASE_W-1:0] BASE_MIN = 7'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 7'd64;

    // Digit store addressing.
    localparam int DIGIT_AW = $clog2(MAX_DIGITS);
    localparam logic [DIGIT_AW-1:0] DIGIT_LAST = DIGIT_AW'(MAX_DIGITS - 1);

    // Divider bit counter.
    localparam int DIV_CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [DIV_CNT_W-1:0] DIV_CNT_LAST = DIV_CNT_W'(VALUE_WIDTH - 1);

    // Command queue between front and back end.
    localparam int QDEPTH = 2;
    localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // ASCII anchors of the alphabet.
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_NONE    = 8'h00;

    // Input item as seen on the top level.
    typedef struct packed {
        logic [IN_VALUE_W-1:0] value;
        logic [BASE_W-1:0]     base;
    } in_t;

    // Result item as seen on the top level.
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              error;
    } out_t;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic [BASE_W-1:0]      base;
        logic                   err;
    } cmd_t;

    // Divider status and result.
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainder;
    } div_rsp_t;

    // Maps a digit to its symbol: 0-9, a-z, A-Z, '+', '/'.
    function automatic logic [CHAR_W-1:0] symbol_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dw;
        logic [CHAR_W-1:0] c;
        dw = {2'b00, d};
        if (d < 6'd10) begin
            c = dw + CH_ZERO;
        end else if (d < 6'd36) begin
            c = dw - 8'd10 + CH_LOWER_A;
        end else if (d < 6'd62) begin
            c = dw - 8'd36 + CH_UPPER_A;
        end else if (d == 6'd62) begin
            c = CH_PLUS;
        end else begin
            c = CH_SLASH;
        end
        return c;
    endfunction

endpackage

// File: sv/itrd_front.sv
// Front end: accepts number items, checks the base and forms queue commands.
`timescale 1ns / 1ps

module itrd_front
    import itrd_pkg::*;
(
    input  logic  number_valid,
    output logic  number_ready,
    input  in_t   number,
    output logic  q_valid,
    input  logic  q_ready,
    output cmd_t  q_data
);

    logic base_ok;

    // A base outside the supported range turns the item into an error command.
    always_comb
    begin
        base_ok = number.base inside {[BASE_MIN:BASE_MAX]};
    end

    // The low VALUE_WIDTH bits of the value take part in the conversion; here that is all of it.
    always_comb
    begin
        q_data.value = number.value[VALUE_WIDTH-1:0];
        q_data.base  = number.base;
        q_data.err   = !base_ok;
    end

    assign q_valid      = number_valid;
    assign number_ready = q_ready;

endmodule

// File: sv/itrd_fifo.sv
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module itrd_fifo
    import itrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output cmd_t rd_data
);

    cmd_t           entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;
    logic           push;
    logic           pop;

    assign wr_ready = (count_reg != QCW'(QDEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Pointer and fill count update, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : QAW'(wr_ptr_reg + 1'b1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : QAW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop) begin
            count_next = QCW'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = QCW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/itrd_div.sv
// Radix divider: restoring division, one quotient bit per cycle.
`timescale 1ns / 1ps

module itrd_div
    import itrd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [BASE_W-1:0]      divisor,
    output div_rsp_t               rsp
);

    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [VALUE_WIDTH-1:0] quo_next;
    logic [DIGIT_W-1:0]     rem_reg;
    logic [DIGIT_W-1:0]     rem_next;
    logic [BASE_W-1:0]      divisor_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    logic [BASE_W-1:0]      rem_shift;
    logic [BASE_W-1:0]      rem_sub;
    logic                   fits;

    // One shift and trial subtraction. The partial remainder stays below the
    // divisor, so it fits in six bits and the shifted value in seven.
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
        fits      = (rem_shift >= divisor_reg);
        rem_sub   = rem_shift - divisor_reg;
    end

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_LAST;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_next = fits ? rem_sub[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = DIV_CNT_W'(cnt_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            divisor_reg <= divisor;
        end
    end

    always_comb
    begin
        rsp.done      = done_reg;
        rsp.quotient  = quo_reg;
        rsp.remainder = rem_reg;
    end

endmodule

// File: sv/itrd_back.sv
// Back end: divides out digits, emits them most significant first, or flags a bad base.
`timescale 1ns / 1ps
`include "integer_to_radix_digit_string_top_defines.svh"

module itrd_back
    import itrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic [DIGIT_AW-1:0]    ptr_reg;
    logic [DIGIT_AW-1:0]    ptr_next;
    logic [BASE_W-1:0]      base_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_t                   out_reg;
    out_t                   out_next;
    logic [DIGIT_W-1:0]     digit_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0]     rd_data_reg;
    logic                   slot_free;
    logic                   load;
    logic                   wr_en;
    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic [BASE_W-1:0]      div_divisor;
    div_rsp_t               div_rsp;

    itrd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp)
    );

    assign slot_free = !out_valid_reg || out_ready;

    // Sequencer: take a command, divide until the quotient is spent or the store is full,
    // then read the digits back from the top down; an error command gives one error item.
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        cmd_ready      = 1'b0;
        div_start      = 1'b0;
        div_dividend   = cmd.value;
        div_divisor    = cmd.base;
        wr_en          = 1'b0;
        load           = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = slot_free;
                if (cmd_valid && slot_free) begin
                    if (cmd.err) begin
                        load     = 1'b1;
                        out_next = '{character: CH_NONE, last: 1'b1, error: 1'b1};
                    end else begin
                        div_start  = 1'b1;
                        ptr_next   = '0;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done) begin
                    wr_en = 1'b1;
                    if ((div_rsp.quotient == '0) || (ptr_reg == DIGIT_LAST)) begin
                        state_next = S_RD;
                    end else begin
                        ptr_next     = DIGIT_AW'(ptr_reg + 1'b1);
                        div_start    = 1'b1;
                        div_dividend = div_rsp.quotient;
                        div_divisor  = base_reg;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free) begin
                    load     = 1'b1;
                    out_next = '{character: symbol_of(rd_data_reg),
                                 last: (ptr_reg == '0), error: 1'b0};
                    if (ptr_reg == '0) begin
                        state_next = S_IDLE;
                    end else begin
                        ptr_next   = DIGIT_AW'(ptr_reg - 1'b1);
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (load) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (cmd_valid && cmd_ready) begin
            base_reg <= cmd.base;
        end
    end

    // Digit store: one write port from the divider, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            digit_mem[ptr_reg] <= div_rsp.remainder;
        end
        rd_data_reg <= digit_mem[ptr_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // The divider only finishes while the sequencer waits for it.
    `ITRD_ASSERT_IMP(a_done_in_div, div_rsp.done, state_reg == S_DIV,
        "divider finished outside the divide phase")
    // An error item is a single, final item with no character.
    `ITRD_ASSERT_IMP(a_err_single, out_valid_reg && out_reg.error,
        out_reg.last && (out_reg.character == CH_NONE), "malformed error item")
    // After the final digit is loaded the sequencer is free again.
    `ITRD_ASSERT_NXT(a_last_idle, load && out_next.last && !out_next.error,
        state_reg == S_IDLE, "sequencer busy after final digit")

endmodule

// File: sv/integer_to_radix_digit_string_top.sv
// Top level of the integer to radix digit string converter.
//
//  Channel   Direction  Handshake                    Payload
//  number    in         number_valid / number_ready  in_t  (value, base)
//  symbol    out        symbol_valid / symbol_ready  out_t (character, last, error)
//
// One radix divider, reused for every digit, retires one quotient bit a cycle; the
// digits are then read from the digit store through its registered read port and
// emitted most significant first. A bad base skips the divider: the back end loads
// its error item straight into the output register.
// Reset clears all control state; the digit store is not cleared and needs no pass.
// A two-entry command queue lets the front accept items while the back end works,
// and the output register holds an item while symbol_ready is low.
`timescale 1ns / 1ps

module integer_to_radix_digit_string_top
    import itrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic number_valid,
    output logic number_ready,
    input  in_t  number,
    output logic symbol_valid,
    input  logic symbol_ready,
    output out_t symbol
);

    logic q_in_valid;
    logic q_in_ready;
    cmd_t q_in_data;
    logic q_out_valid;
    logic q_out_ready;
    cmd_t q_out_data;

    itrd_front u_front (
        .number_valid (number_valid),
        .number_ready (number_ready),
        .number       (number),
        .q_valid      (q_in_valid),
        .q_ready      (q_in_ready),
        .q_data       (q_in_data)
    );

    itrd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_in_valid),
        .wr_ready (q_in_ready),
        .wr_data  (q_in_data),
        .rd_valid (q_out_valid),
        .rd_ready (q_out_ready),
        .rd_data  (q_out_data)
    );

    itrd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_out_valid),
        .cmd_ready (q_out_ready),
        .cmd       (q_out_data),
        .out_valid (symbol_valid),
        .out_ready (symbol_ready),
        .out_data  (symbol)
    );

endmodule

// File: tb/sv/itrd_symbol_checker.sv
// Checker that predicts the digit characters of each accepted number and compares them.
`timescale 1ns / 1ps

module itrd_symbol_checker
    import itrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        number_valid,
    input  logic        number_ready,
    input  in_t         number,
    input  logic        symbol_valid,
    input  logic        symbol_ready,
    input  out_t        symbol,
    output int unsigned mismatches,
    output int unsigned symbols_owed
);

    // The 64 symbols, first symbol in the most significant byte.
    localparam logic [64*CHAR_W-1:0] ALPHABET =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ+/";

    // Characters still owed by the block, oldest first.
    out_t expected_symbols[$];

    initial
    begin
        mismatches   = 0;
        symbols_owed = 0;
    end

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] digit);
        return ALPHABET[(63 - digit) * CHAR_W +: CHAR_W];
    endfunction

    // Divides the number down and queues its characters, most significant first; a bad base queues one error item.
    function automatic void queue_digits(input in_t item);
        logic [VALUE_WIDTH-1:0] quotient;
        logic [VALUE_WIDTH-1:0] radix;
        logic [DIGIT_W-1:0]     remainders [MAX_DIGITS];
        int                     count;
        int                     k;
        out_t                   s;
        if (item.base < BASE_MIN || item.base > BASE_MAX)
        begin
            s.character = CH_NONE;
            s.last      = 1'b1;
            s.error     = 1'b1;
            expected_symbols.push_back(s);
            return;
        end
        quotient = item.value[VALUE_WIDTH-1:0];
        radix    = VALUE_WIDTH'(item.base);
        count    = 0;
        // A zero value still yields one digit.
        do
        begin
            remainders[count] = DIGIT_W'(quotient % radix);
            quotient = quotient / radix;
            count++;
        end while (quotient != 0 && count < MAX_DIGITS);
        for (k = count - 1; k >= 0; k--)
        begin
            s.character = glyph(remainders[k]);
            s.last      = (k == 0);
            s.error     = 1'b0;
            expected_symbols.push_back(s);
        end
    endfunction

    // Compare each delivered character with the oldest one owed, then predict new numbers.
    always @(posedge clk)
    begin : watch
        out_t want;
        if (rst_n && symbol_valid && symbol_ready)
        begin
            if (expected_symbols.size() == 0)
            begin
                $display("%0t: unexpected symbol item: char %h last %b error %b",
                         $time, symbol.character, symbol.last, symbol.error);
                mismatches++;
            end
            else
            begin
                want = expected_symbols.pop_front();
                if (want.character !== symbol.character || want.last !== symbol.last ||
                    want.error !== symbol.error)
                begin
                    $display("%0t: expected %h last %b err %b, got %h last %b err %b",
                             $time, want.character, want.last, want.error,
                             symbol.character, symbol.last, symbol.error);
                    mismatches++;
                end
            end
        end
        if (rst_n && number_valid && number_ready)
        begin
            queue_digits(number);
        end
        symbols_owed = expected_symbols.size();
    end

endmodule

// File: tb/sv/tb_integer_to_radix_digit_string_top.sv
// Testbench top: drives numbers and symbol back-pressure, and gives the verdict.
`timescale 1ns / 1ps

module tb_integer_to_radix_digit_string_top;
    import itrd_pkg::*;

    localparam int RANDOM_ITEMS = 119;
    localparam int CALM_ITEMS   = 20;
    localparam int HOLD_AT      = 50;
    localparam int HOLD_CYCLES  = 6000;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 32;
    localparam int RUN_LIMIT_NS = 60_000_000;

    logic        clk;
    logic        rst_n;
    logic        number_valid;
    logic        number_ready;
    in_t         number;
    logic        symbol_valid;
    logic        symbol_ready;
    out_t        symbol;
    int unsigned mismatches;
    int unsigned symbols_owed;
    int unsigned items_sent;
    int unsigned total_items;
    bit          calm;
    in_t         directed_numbers[$];

    integer_to_radix_digit_string_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_ready (number_ready),
        .number       (number),
        .symbol_valid (symbol_valid),
        .symbol_ready (symbol_ready),
        .symbol       (symbol)
    );

    itrd_symbol_checker symbol_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_ready (number_ready),
        .number       (number),
        .symbol_valid (symbol_valid),
        .symbol_ready (symbol_ready),
        .symbol       (symbol),
        .mismatches   (mismatches),
        .symbols_owed (symbols_owed)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("integer_to_radix_digit_string_top: mismatch");
        $finish;
    end

    function automatic in_t number_item(input logic [63:0] value, input logic [6:0] base);
        in_t item;
        item.value = value;
        item.base  = base;
        return item;
    endfunction

    // Mostly moderate values and good bases; a few full-width values, zeros and bad bases.
    function automatic in_t random_number();
        logic [63:0] value;
        logic [6:0]  base;
        int          pick;
        value = {$urandom, $urandom};
        pick  = $urandom_range(0, 19);
        if (pick == 0)
        begin
            value = '0;
        end
        else if (pick > 2)
        begin
            value = value >> $urandom_range(0, 63);
        end
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            base = 7'($urandom_range(0, 127));
        end
        else
        begin
            base = 7'($urandom_range(BASE_MIN, BASE_MAX));
        end
        return number_item(value, base);
    endfunction

    // Offer one number item, after an occasional gap, and wait until it is taken.
    task automatic offer_number(input in_t item);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 16);
            number_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        number_valid = 1'b1;
        number       = item;
        do @(posedge clk); while (!number_ready);
        items_sent++;
        if (items_sent >= total_items - CALM_ITEMS)
        begin
            calm = 1'b1;
        end
    endtask

    // Receiver: random stall bursts, one long hold-off, and none near the end.
    initial
    begin : receiver
        int  stall_left;
        bit  hold_done;
        stall_left   = 0;
        hold_done    = 1'b0;
        symbol_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && items_sent >= HOLD_AT)
            begin
                // Keep the output blocked long enough for the command queue to fill.
                hold_done    = 1'b1;
                symbol_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (!calm && stall_left == 0 && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0)
            begin
                symbol_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                symbol_ready = 1'b1;
            end
        end
    end

    // Sender: reset, directed numbers, random numbers, then drain and verdict.
    initial
    begin
        number_valid = 1'b0;
        number       = '0;
        rst_n        = 1'b0;
        calm         = 1'b0;
        items_sent   = 0;

        // Zero values, extreme values in every alphabet region, and bad bases.
        directed_numbers.push_back(number_item(64'd0, 7'd10));
        directed_numbers.push_back(number_item(64'd0, 7'd64));
        directed_numbers.push_back(number_item(64'd0, 7'd0));
        directed_numbers.push_back(number_item(64'd1, 7'd2));
        directed_numbers.push_back(number_item('1, 7'd2));
        directed_numbers.push_back(number_item('1, 7'd3));
        directed_numbers.push_back(number_item('1, 7'd10));
        directed_numbers.push_back(number_item('1, 7'd16));
        directed_numbers.push_back(number_item('1, 7'd63));
        directed_numbers.push_back(number_item('1, 7'd64));
        directed_numbers.push_back(number_item(64'd35, 7'd36));
        directed_numbers.push_back(number_item(64'd36, 7'd64));
        directed_numbers.push_back(number_item(64'd61, 7'd64));
        directed_numbers.push_back(number_item(64'd62, 7'd64));
        directed_numbers.push_back(number_item(64'd63, 7'd64));
        directed_numbers.push_back(number_item(64'd64, 7'd64));
        directed_numbers.push_back(number_item(64'h8000_0000_0000_0000, 7'd2));
        directed_numbers.push_back(number_item(64'h5555_5555_5555_5555, 7'd7));
        directed_numbers.push_back(number_item(64'd123, 7'd1));
        directed_numbers.push_back(number_item(64'd5, 7'd65));
        directed_numbers.push_back(number_item('1, 7'd127));
        total_items = directed_numbers.size() + RANDOM_ITEMS;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_numbers[i])
        begin
            offer_number(directed_numbers[i]);
        end
        repeat (RANDOM_ITEMS)
        begin
            offer_number(random_number());
        end
        @(negedge clk);
        number_valid = 1'b0;

        // Every number gives at least one item, so nothing is in flight once none is owed.
        while (symbols_owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && symbols_owed == 0)
        begin
            $display("integer_to_radix_digit_string_top: match");
        end
        else
        begin
            $display("integer_to_radix_digit_string_top: mismatch");
        end
        $finish;
    end

endmodule
